// File: rtl/tpcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tpcr_pkg;
  localparam int NumConn = 8;
  localparam int SlotW = $clog2(NumConn);

  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_SYNRCVD = 2'd1;
  localparam logic [1:0] ST_ESTAB = 2'd2;
  localparam logic [1:0] ST_LASTACK = 2'd3;

  localparam logic [1:0] KIND_RST = 2'd0;
  localparam logic [1:0] KIND_SYNACK = 2'd1;
  localparam logic [1:0] KIND_ACK = 2'd2;
  localparam logic [1:0] KIND_FINACK = 2'd3;

  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_OPENED = 3'd1;
  localparam logic [2:0] EV_ESTAB = 3'd2;
  localparam logic [2:0] EV_CLOSING = 3'd3;
  localparam logic [2:0] EV_CLOSED = 3'd4;

  localparam logic [1:0] REG_LOCAL_IP = 2'd0;
  localparam logic [1:0] REG_LISTEN_PORT = 2'd1;
  localparam logic [1:0] REG_WINDOW = 2'd2;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_in;
    logic [31:0] ack_in;
    logic        flag_ack;
    logic        flag_psh;
    logic        flag_syn;
    logic        flag_fin;
    logic [15:0] payload_len;
  } seg_t;

  typedef struct packed {
    logic        send_segment;
    logic [1:0]  reply_kind;
    logic [31:0] reply_dst_ip;
    logic [15:0] reply_dst_port;
    logic [15:0] reply_src_port;
    logic [31:0] reply_seq;
    logic [31:0] reply_ack;
    logic [15:0] reply_checksum;
    logic [15:0] delivered_len;
    logic [2:0]  conn_slot;
    logic [2:0]  conn_event;
  } reply_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic lookup;
    logic decide;
    logic sum;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_sts_t;

  function automatic logic [15:0] hdr_flags(input logic [1:0] kind);
    logic [15:0] f;
    unique case (kind)
      KIND_RST:    f = 16'h5014;
      KIND_SYNACK: f = 16'h5012;
      KIND_ACK:    f = 16'h5010;
      default:     f = 16'h5011;
    endcase
    return f;
  endfunction
endpackage
`default_nettype wire

// File: rtl/tpcr_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tpcr_seg_if;
  logic valid;
  logic ready;
  tpcr_pkg::seg_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tpcr_reply_if;
  logic valid;
  logic ready;
  tpcr_pkg::reply_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/tcp_passive_connection_responder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Payload             Handshake
// seg_if    in         tpcr_pkg::seg_t     valid/ready
// rep_if    out        tpcr_pkg::reply_t   valid/ready
// cfg       in         index 2b, data 32b  write enable only
//
// The acceptance edge captures the segment; its reply reaches the output
// register after table lookup, decision and table write, checksum sum and
// checksum fold. The core then returns to idle, so the next segment is not
// taken until the previous reply is loaded. A stalled sink holds the core
// in its last step. Reset clears the slot states, local IP and listen port
// and sets the window to 8192; slot contents need no clearing.
module tcp_passive_connection_responder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  tpcr_seg_if.sink         seg_if,
  tpcr_reply_if.source     rep_if,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i
);
  tpcr_pkg::dp_cmd_t cmd;
  tpcr_pkg::dp_sts_t sts;

  // The controller sequences each item through the datapath steps.
  tpcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (seg_if.valid),
    .in_ready_o (seg_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the table, configuration and reply register.
  tpcr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .seg_i       (seg_if.data),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (rep_if.valid),
    .out_ready_i (rep_if.ready),
    .out_data_o  (rep_if.data)
  );
endmodule
`default_nettype wire

// File: rtl/tpcr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tpcr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire tpcr_pkg::dp_sts_t sts_i,
  output tpcr_pkg::dp_cmd_t      cmd_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.lookup = 1'b1;
        state_d = S_DEC;
      end
      S_DEC: begin
        cmd_o.decide = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (!sts_i.out_full) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

// File: rtl/tpcr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module tpcr_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tpcr_pkg::dp_cmd_t cmd_i,
  output tpcr_pkg::dp_sts_t      sts_o,
  input  wire tpcr_pkg::seg_t    seg_i,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [31:0]       cfg_wdata_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output tpcr_pkg::reply_t       out_data_o
);
  localparam int N = tpcr_pkg::NumConn;
  localparam int SW = tpcr_pkg::SlotW;

  logic [31:0] local_ip_q;
  logic [15:0] listen_port_q, window_q;

  logic [1:0]  st_q [N];
  logic [31:0] rip_q [N];
  logic [15:0] rport_q [N];
  logic [31:0] sseq_q [N];
  logic [31:0] rack_q [N];

  tpcr_pkg::seg_t seg_q;
  logic          hit_q, free_ok_q;
  logic [SW-1:0] hit_idx_q, free_idx_q;
  tpcr_pkg::reply_t res_q, out_q;
  logic [19:0]   sum_q;
  logic          out_v_q;

  // Lookup: priority search over the slots.
  logic          hit_c, free_ok_c;
  logic [SW-1:0] hit_idx_c, free_idx_c;
  always_comb begin
    hit_c = 1'b0;
    free_ok_c = 1'b0;
    hit_idx_c = '0;
    free_idx_c = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (st_q[i] != tpcr_pkg::ST_FREE) begin
        if (rip_q[i] == seg_q.src_ip && rport_q[i] == seg_q.src_port) begin
          hit_c = 1'b1;
          hit_idx_c = SW'(i);
        end
      end else begin
        free_ok_c = 1'b1;
        free_idx_c = SW'(i);
      end
    end
  end

  // Decision on the looked-up slot.
  tpcr_pkg::reply_t dec_c;
  logic          wr_c;
  logic [SW-1:0] wr_idx_c;
  logic [1:0]    wr_st_c;
  logic [31:0]   wr_rip_c, wr_sseq_c, wr_rack_c;
  logic [15:0]   wr_rport_c;
  logic [31:0]   hs_seq;
  always_comb begin
    dec_c = '0;
    wr_c = 1'b0;
    wr_idx_c = hit_idx_q;
    wr_st_c = st_q[hit_idx_q];
    wr_rip_c = rip_q[hit_idx_q];
    wr_rport_c = rport_q[hit_idx_q];
    wr_sseq_c = sseq_q[hit_idx_q];
    wr_rack_c = rack_q[hit_idx_q];
    hs_seq = sseq_q[hit_idx_q];
    if (!hit_q) begin
      if (seg_q.dst_port == listen_port_q && seg_q.flag_syn) begin
        if (free_ok_q) begin
          wr_c = 1'b1;
          wr_idx_c = free_idx_q;
          wr_st_c = tpcr_pkg::ST_SYNRCVD;
          wr_rip_c = seg_q.src_ip;
          wr_rport_c = seg_q.src_port;
          wr_sseq_c = '0;
          wr_rack_c = seg_q.seq_in + 32'd1;
          dec_c.send_segment = 1'b1;
          dec_c.reply_kind = tpcr_pkg::KIND_SYNACK;
          dec_c.reply_ack = seg_q.seq_in + 32'd1;
          dec_c.conn_slot = 3'(free_idx_q);
          dec_c.conn_event = tpcr_pkg::EV_OPENED;
        end
      end else begin
        dec_c.send_segment = 1'b1;
        dec_c.reply_kind = tpcr_pkg::KIND_RST;
        dec_c.reply_ack = seg_q.seq_in + 32'd1;
      end
    end else begin
      dec_c.conn_slot = 3'(hit_idx_q);
      unique case (st_q[hit_idx_q])
        tpcr_pkg::ST_SYNRCVD: begin
          wr_c = 1'b1;
          wr_sseq_c = seg_q.ack_in;
          wr_st_c = tpcr_pkg::ST_ESTAB;
          dec_c.conn_event = tpcr_pkg::EV_ESTAB;
        end
        tpcr_pkg::ST_ESTAB: begin
          if ((seg_q.flag_ack || seg_q.flag_psh) && seg_q.payload_len != 16'd0) begin
            wr_c = 1'b1;
            wr_rack_c = seg_q.seq_in + 32'(seg_q.payload_len);
            dec_c.send_segment = 1'b1;
            dec_c.reply_kind = tpcr_pkg::KIND_ACK;
            dec_c.reply_seq = hs_seq;
            dec_c.reply_ack = seg_q.seq_in + 32'(seg_q.payload_len);
            dec_c.delivered_len = seg_q.payload_len;
          end else if (seg_q.flag_fin) begin
            wr_c = 1'b1;
            wr_st_c = tpcr_pkg::ST_LASTACK;
            dec_c.send_segment = 1'b1;
            dec_c.reply_kind = tpcr_pkg::KIND_FINACK;
            dec_c.reply_seq = hs_seq;
            dec_c.reply_ack = seg_q.seq_in + 32'd1;
            dec_c.conn_event = tpcr_pkg::EV_CLOSING;
          end
        end
        default: begin
          if (seg_q.flag_ack && seg_q.ack_in == hs_seq + 32'd1) begin
            wr_c = 1'b1;
            wr_st_c = tpcr_pkg::ST_FREE;
            dec_c.conn_event = tpcr_pkg::EV_CLOSED;
          end
        end
      endcase
    end
    if (dec_c.send_segment) begin
      dec_c.reply_dst_ip = seg_q.src_ip;
      dec_c.reply_dst_port = seg_q.src_port;
      dec_c.reply_src_port = seg_q.dst_port;
    end
  end

  // Checksum split in two: a wide sum of the 16-bit words, then the fold.
  logic [19:0] sum_c;
  always_comb begin
    sum_c = 20'(local_ip_q[31:16]) + 20'(local_ip_q[15:0])
          + 20'(res_q.reply_dst_ip[31:16]) + 20'(res_q.reply_dst_ip[15:0])
          + 20'd26 + 20'(res_q.reply_src_port) + 20'(res_q.reply_dst_port)
          + 20'(res_q.reply_seq[31:16]) + 20'(res_q.reply_seq[15:0])
          + 20'(res_q.reply_ack[31:16]) + 20'(res_q.reply_ack[15:0])
          + 20'(tpcr_pkg::hdr_flags(res_q.reply_kind)) + 20'(window_q);
  end
  logic [16:0] f1;
  logic [15:0] f2;
  always_comb begin
    f1 = 17'(sum_q[15:0]) + 17'(sum_q[19:16]);
    f2 = f1[15:0] + 16'(f1[16]);
  end

  // Final reply with its checksum, loaded into the output register.
  tpcr_pkg::reply_t fin_c;
  always_comb begin
    fin_c = res_q;
    fin_c.reply_checksum = res_q.send_segment ? ~f2 : 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q <= '0;
      listen_port_q <= '0;
      window_q <= 16'd8192;
      out_v_q <= 1'b0;
      for (int i = 0; i < N; i++) st_q[i] <= tpcr_pkg::ST_FREE;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tpcr_pkg::REG_LOCAL_IP:    local_ip_q <= cfg_wdata_i;
          tpcr_pkg::REG_LISTEN_PORT: listen_port_q <= cfg_wdata_i[15:0];
          tpcr_pkg::REG_WINDOW:      window_q <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (cmd_i.decide && wr_c) st_q[wr_idx_c] <= wr_st_c;
      if (cmd_i.finish) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) seg_q <= seg_i;
    if (cmd_i.lookup) begin
      hit_q <= hit_c;
      free_ok_q <= free_ok_c;
      hit_idx_q <= hit_idx_c;
      free_idx_q <= free_idx_c;
    end
    if (cmd_i.decide) begin
      res_q <= dec_c;
      if (wr_c) begin
        rip_q[wr_idx_c] <= wr_rip_c;
        rport_q[wr_idx_c] <= wr_rport_c;
        sseq_q[wr_idx_c] <= wr_sseq_c;
        rack_q[wr_idx_c] <= wr_rack_c;
      end
    end
    if (cmd_i.sum) sum_q <= sum_c;
    if (cmd_i.finish) out_q <= fin_c;
  end

  assign sts_o.out_full = out_v_q && !out_ready_i;
  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;
endmodule
`default_nettype wire

// File: rtl/tpcr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module tpcr_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire tpcr_pkg::reply_t out_data
);
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("back to back accept");
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data.send_segment |-> out_data.reply_checksum == 16'd0)
    else $error("checksum on silent reply");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("reply dropped");
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.delivered_len != 16'd0 |->
      out_data.reply_kind == tpcr_pkg::KIND_ACK) else $error("len without ack");
endmodule

bind tcp_passive_connection_responder_unit tpcr_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(seg_if.valid), .in_ready(seg_if.ready),
  .out_valid(rep_if.valid), .out_ready(rep_if.ready), .out_data(rep_if.data)
);
`default_nettype wire
